[rtl/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants for the pattern count deletion DP
// Holds the stage entry type, the entry constants, the register map and the
// compare function that every cell and the head use.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

	localparam int COUNT_W = 16;
	localparam int COST_W  = 40;
	localparam int SYM_W   = 8;
	localparam int DCOST_W = 16;
	localparam int PAT_W   = 48;
	localparam int PAT_SYMS = PAT_W / SYM_W;

	// Pattern register reset spells "bessie", first symbol in the lowest byte.
	localparam logic [PAT_W-1:0] PAT_RESET = 48'h656973736562;

	// Register index decoded from the APB address.
	localparam logic REG_PATTERN = 1'b0;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COST_W-1:0]  COST_MAX  = '1;

	// One DP stage: best (count, cost) reachable, and whether it is reachable.
	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
		logic [COST_W-1:0]  cost;
	} entry_t;

	localparam entry_t ENTRY_NONE  = '{valid: 1'b0, count: '0, cost: '0};
	localparam entry_t ENTRY_START = '{valid: 1'b1, count: '0, cost: '0};

	// True when entry a is strictly better than entry b: higher count wins,
	// equal counts go to the lower cost, and an unreachable entry never wins.
	function automatic logic ent_better(input entry_t a, input entry_t b);
		logic res;
		if (!a.valid) begin
			res = 1'b0;
		end else if (!b.valid) begin
			res = 1'b1;
		end else begin
			res = (a.count > b.count) || ((a.count == b.count) && (a.cost < b.cost));
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/pdc_cell.sv]
// ----------------------------------------------------------------------------
// pdc_cell: one matched-prefix stage of the deletion DP
// Holds the best entry with j pattern symbols matched and updates it from its
// own value (symbol deleted) or from the stage before it (symbol matched).
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_cell
	import pdc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               clear,
	input  wire logic [SYM_W-1:0]   symbol,
	input  wire logic [SYM_W-1:0]   pat_sym,
	input  wire logic [DCOST_W-1:0] del_cost,
	input  wire entry_t             prev_old,
	output entry_t                  cur_old,
	output entry_t                  cur_next
);

	entry_t            stage_q;
	entry_t            stay;
	logic [COST_W:0]   cost_sum;
	logic              take_prev;

	// A start of string makes the stored entry read as unreachable.
	assign cur_old = clear ? ENTRY_NONE : stage_q;

	// Candidate that deletes this symbol: pay its cost, saturating.
	assign cost_sum = {1'b0, cur_old.cost} + {{(COST_W+1-DCOST_W){1'b0}}, del_cost};

	always_comb begin
		stay = ENTRY_NONE;
		if (cur_old.valid) begin
			stay.valid = 1'b1;
			stay.count = cur_old.count;
			stay.cost  = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
		end
	end

	// Matching extends the previous stage unless staying is strictly better.
	assign take_prev = (symbol == pat_sym) && !ent_better(stay, prev_old);

	always_comb begin
		if (take_prev) begin
			cur_next = prev_old.valid ? prev_old : ENTRY_NONE;
		end else begin
			cur_next = stay;
		end
	end

	// Stage register, updated once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ENTRY_NONE;
		end else if (advance) begin
			stage_q <= cur_next;
		end
	end

endmodule

`default_nettype wire

[rtl/pdc_head.sv]
// ----------------------------------------------------------------------------
// pdc_head: idle stage of the deletion DP
// Holds the best entry with no copy under way and folds in a copy completed
// by the last cell in the same beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_head
	import pdc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   advance,
	input  wire logic   clear,
	input  wire entry_t tail_next,
	output entry_t      head_old,
	output entry_t      head_next
);

	entry_t stage0_q;
	entry_t done;
	logic   take_done;

	// A start of string restarts from zero copies at zero cost.
	assign head_old = clear ? ENTRY_START : stage0_q;

	// A full match in the last cell becomes one more completed copy.
	always_comb begin
		done = ENTRY_NONE;
		if (tail_next.valid) begin
			done.valid = 1'b1;
			done.count = (tail_next.count == COUNT_MAX) ? COUNT_MAX : tail_next.count + 1'b1;
			done.cost  = tail_next.cost;
		end
	end

	assign take_done = done.valid && !ent_better(head_old, done);
	assign head_next = take_done ? done : head_old;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage0_q <= ENTRY_START;
		end else if (advance) begin
			stage0_q <= head_next;
		end
	end

endmodule

`default_nettype wire

[rtl/pattern_count_deletion_dp.sv]
// ----------------------------------------------------------------------------
// pattern_count_deletion_dp: streaming max-copies / min-deletion-cost DP
// Top level with the APB pattern register, the chain of stage cells, the
// idle stage and the output register.
// ----------------------------------------------------------------------------
// The block takes one symbol beat per clock while the result stream is not
// stalled and returns one result beat per symbol, registered in the output
// register and shown in the cycle after the symbol is accepted. Every beat
// updates all stages at once through a row of PATTERN_LEN cells, each doing
// one saturating add and one compare; the idle stage then folds in a
// completed copy, so the rate is one beat per cycle when not stalled. A new
// symbol is taken only when the output register is empty or being drained.
// Set s_tuser on the first symbol of a string to restart the count.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_count_deletion_dp
	import pdc_pkg::*;
#(
	parameter int PATTERN_LEN = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	// Symbol stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [7:0] symbol, [23:8] deletion_cost
	input  wire logic        s_tuser,   // [0] start_of_string
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata    // [15:0] best_count, [55:16] best_cost
);

	logic [PAT_W-1:0]   pattern_q;
	logic               reg_idx;
	logic               advance;
	logic [SYM_W-1:0]   symbol;
	logic [DCOST_W-1:0] del_cost;
	entry_t             old_e  [PATTERN_LEN+1];
	entry_t             next_e [PATTERN_LEN+1];
	logic               m_tvalid_q;
	logic [55:0]        m_tdata_q;

	// Pattern register on the APB port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_RESET;
		end else if (psel && penable && pwrite && pready && (reg_idx == REG_PATTERN)) begin
			pattern_q <= pwdata[PAT_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PATTERN: prdata = {{(64-PAT_W){1'b0}}, pattern_q};
			default:     prdata = '0;
		endcase
	end

	// Input handshake; the output register parts the two sides.
	assign s_tready = !m_tvalid_q || m_tready;
	assign advance  = s_tvalid && s_tready;
	assign symbol   = s_tdata[7:0];
	assign del_cost = s_tdata[23:8];

	// Idle stage.
	pdc_head u_head (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.clear     (s_tuser),
		.tail_next (next_e[PATTERN_LEN]),
		.head_old  (old_e[0]),
		.head_next (next_e[0])
	);

	// Row of matched-prefix cells, cell j matching pattern symbol j-1.
	for (genvar j = 1; j <= PATTERN_LEN; j++) begin : g_cell
		logic [SYM_W-1:0] pat_sym;

		if (j - 1 < PAT_SYMS) begin : g_sym
			assign pat_sym = pattern_q[SYM_W*(j-1) +: SYM_W];
		end else begin : g_zero
			assign pat_sym = '0;
		end

		pdc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.clear    (s_tuser),
			.symbol   (symbol),
			.pat_sym  (pat_sym),
			.del_cost (del_cost),
			.prev_old (old_e[j-1]),
			.cur_old  (old_e[j]),
			.cur_next (next_e[j])
		);
	end

	// Output register holding one result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {next_e[0].cost, next_e[0].count};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
